/* rtl/arp_cache_with_aging_defines.svh */
// Assertion macros shared by the ARP cache RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ARP_CACHE_WITH_AGING_DEFINES_SVH
`define ARP_CACHE_WITH_AGING_DEFINES_SVH

// Check a consequence in the same cycle.
`define ACP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check a consequence in the next cycle.
`define ACP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/acp_pkg.sv */
package acp_pkg;

	// table geometry
	localparam int ROWS  = 8;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	// operation codes
	localparam logic [1:0] OP_LOOKUP    = 2'd0;
	localparam logic [1:0] OP_UPDATE    = 2'd1;
	localparam logic [1:0] OP_FIND_FREE = 2'd2;

	localparam logic [31:0] AGE_LIMIT_RESET = 32'd300000;

	// request held steady while its token walks the row chain
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] now;
	} req_t;

	// token handed from row cell to row cell
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [ROW_W-1:0] idx;
		logic [47:0]      mac;
		logic             efound;
		logic [ROW_W-1:0] eidx;
	} tok_t;

	// insert write broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] idx;
	} ins_t;

endpackage

/* rtl/acp_cell.sv */
module acp_cell
	import acp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] my_idx,
	input  req_t             req,
	input  logic [31:0]      age_limit,
	input  ins_t             ins,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] stamp_q;
	tok_t        tok_q;

	logic [31:0] age;
	logic        expired;
	logic [31:0] eff_ip;
	logic        is_empty;
	logic        match;
	logic        take_hit;
	logic        refresh;
	logic        ins_here;
	tok_t        tok_nxt;

	// age the row, then compare against the request
	always_comb begin
		age      = req.now - stamp_q;
		expired  = (ip_q != 32'd0) && (age >= age_limit);
		eff_ip   = expired ? 32'd0 : ip_q;
		is_empty = (eff_ip == 32'd0);
		match    = !is_empty && (eff_ip == req.ip);
		take_hit = tok_in.valid && !tok_in.hit && match &&
			((req.op == OP_LOOKUP) || (req.op == OP_UPDATE));
		refresh  = take_hit && (req.op == OP_UPDATE);
		ins_here = ins.en && (ins.idx == my_idx);
	end

	// update the token as it passes
	always_comb begin
		tok_nxt = tok_in;
		if (take_hit) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.idx = my_idx;
			tok_nxt.mac = (req.op == OP_LOOKUP) ? mac_q : req.mac;
		end
		if (tok_in.valid && is_empty && !tok_in.efound) begin
			tok_nxt.efound = 1'b1;
			tok_nxt.eidx   = my_idx;
		end
	end

	// row key: fill on insert, drop on expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q <= 32'd0;
		end else if (ins_here) begin
			ip_q <= req.ip;
		end else if (tok_in.valid && expired) begin
			ip_q <= 32'd0;
		end
	end

	// row payload: write on insert or refresh
	always_ff @(posedge clk) begin
		if (ins_here || refresh) begin
			mac_q   <= req.mac;
			stamp_q <= req.now;
		end
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/arp_cache_with_aging.sv */
// ARP cache with ageing. A request is taken when start is high and busy is
// low; it then walks a chain of ROWS row cells, one cell per cycle, where
// each cell ages its own row and compares it to the key. The answer appears
// on found, row_index, mac_out and was_inserted for exactly one cycle with
// done high, and busy drops in that same cycle, so a new request can be
// started as the previous answer is shown. The answer cannot be held off:
// capture it while done is high. An insert into the first empty row is
// written at the end of the walk. The age limit register is written through
// cfg_valid/cfg_data and should only be changed while busy is low.
`include "arp_cache_with_aging_defines.svh"

module arp_cache_with_aging
	import acp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] target_ip,
	input  logic [47:0] mac_in,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic        found,
	output logic [2:0]  row_index,
	output logic [47:0] mac_out,
	output logic        was_inserted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic        busy_q;
	logic        done_q;
	logic        found_q;
	logic [2:0]  idx_q;
	logic [47:0] mac_q;
	logic        ins_q;
	logic [31:0] age_limit_q;
	req_t        req_q;
	logic        launch_q;

	logic        accept;
	tok_t        tok_w [ROWS+1];
	tok_t        tok_end;
	ins_t        ins;
	logic        r_found;
	logic [ROW_W-1:0] r_idx;
	logic [47:0] r_mac;
	logic        r_ins;

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	// age limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			age_limit_q <= cfg_data;
		end
	end

	// capture the request word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op  <= operation;
			req_q.ip  <= target_ip;
			req_q.mac <= mac_in;
			req_q.now <= now_ms;
		end
	end

	// launch a fresh token into the first cell
	always_comb begin
		tok_w[0]        = '0;
		tok_w[0].valid  = launch_q;
	end

	for (genvar i = 0; i < ROWS; i++) begin : g_row
		acp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_idx    (ROW_W'(i)),
			.req       (req_q),
			.age_limit (age_limit_q),
			.ins       (ins),
			.tok_in    (tok_w[i]),
			.tok_out   (tok_w[i+1])
		);
	end

	assign tok_end = tok_w[ROWS];

	// resolve the walk into a result and an optional insert
	always_comb begin
		r_found = 1'b0;
		r_idx   = '0;
		r_mac   = 48'd0;
		r_ins   = 1'b0;
		ins     = '0;
		case (req_q.op)
			OP_LOOKUP: begin
				if (tok_end.hit) begin
					r_found = 1'b1;
					r_idx   = tok_end.idx;
					r_mac   = tok_end.mac;
				end
			end
			OP_UPDATE: begin
				if (req_q.ip != 32'd0) begin
					if (tok_end.hit) begin
						r_found = 1'b1;
						r_idx   = tok_end.idx;
						r_mac   = req_q.mac;
					end else if (tok_end.efound) begin
						r_found = 1'b1;
						r_idx   = tok_end.eidx;
						r_mac   = req_q.mac;
						r_ins   = 1'b1;
						ins.en  = tok_end.valid;
						ins.idx = tok_end.eidx;
					end
				end
			end
			OP_FIND_FREE: begin
				if (tok_end.efound) begin
					r_found = 1'b1;
					r_idx   = tok_end.eidx;
				end
			end
			default: begin
				r_found = 1'b0;
			end
		endcase
	end

	// control: busy, launch and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= accept;
			done_q   <= tok_end.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tok_end.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	// hold the result word
	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			found_q <= r_found;
			idx_q   <= 3'(r_idx);
			mac_q   <= r_mac;
			ins_q   <= r_ins;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign found        = found_q;
	assign row_index    = idx_q;
	assign mac_out      = mac_q;
	assign was_inserted = ins_q;

	`ACP_ASSERT_NOW(a_done_frees_busy, done_q, !busy_q)
	`ACP_ASSERT_NEXT(a_accept_sets_busy, start && !busy_q, busy_q && launch_q)
	`ACP_ASSERT_NOW(a_token_only_busy, tok_end.valid || launch_q, busy_q)
	`ACP_ASSERT_NOW(a_miss_is_clean, done_q && !found_q,
		(idx_q == 3'd0) && (mac_q == 48'd0) && !ins_q)
	`ACP_ASSERT_NEXT(a_done_one_cycle, done_q, !done_q)

endmodule
